>>> rtl/core/modexp_pkg.sv
package modexp_pkg;

	// Width of every port field of the block
	localparam int unsigned FIELD_WIDTH = 32;

	// Sequencer states of the exponent scan
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE,
		ST_BASE_WAIT,
		ST_STEP,
		ST_ACC_WAIT,
		ST_SQ,
		ST_SQ_WAIT,
		ST_DONE
	} modexp_state_t;

	// Status of the shared multiply-reduce unit
	typedef struct packed {
		logic busy;
		logic done;
	} modexp_mm_status_t;

endpackage

>>> rtl/core/modexp_mulred.sv
// Multiply two residues, then reduce the double-width product modulo m,
// two product bits per cycle by restoring compare-subtract.
module modexp_mulred import modexp_pkg::*; #(
	parameter int unsigned W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [W-1:0]        a,
	input  logic [W-1:0]        b,
	input  logic [W-1:0]        m,
	output modexp_mm_status_t   st,
	output logic [W-1:0]        result
);

	localparam int unsigned CNT_W = $clog2(W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [2*W-1:0]    prod_q;
	logic [W-1:0]      rem_q;

	logic [W:0]        t1;
	logic [W:0]        t2;
	logic [W-1:0]      r1;
	logic [W-1:0]      r2;
	logic              last;

	// Two restoring steps: shift in the next two product bits
	always_comb begin
		t1 = {rem_q, prod_q[2*W-1]};
		if (t1 >= {1'b0, m}) begin
			t1 = t1 - {1'b0, m};
		end
		r1 = t1[W-1:0];
		t2 = {r1, prod_q[2*W-2]};
		if (t2 >= {1'b0, m}) begin
			t2 = t2 - {1'b0, m};
		end
		r2 = t2[W-1:0];
	end

	assign last = (cnt_q == CNT_W'(W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= a * b;
			rem_q  <= '0;
		end else if (busy_q) begin
			prod_q <= {prod_q[2*W-3:0], 2'b00};
			rem_q  <= r2;
		end
	end

	assign st.busy = busy_q;
	assign st.done = done_q;
	assign result  = rem_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("done raised while unit still busy");

	a_start_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> cnt_q == '0)
		else $error("step count not cleared at start");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && m >= W'(2) && $stable(m)) |-> rem_q < m)
		else $error("reduced value not below modulus");

endmodule

>>> rtl/core/modular_exponentiation_core.sv
// Channel   Direction  Handshake                Payload
// input     in         in_valid / in_stall      base_value, exponent
// output    out        out_valid / out_stall    power_result
// config    in         modulus_wr_en            modulus_wr_data
//
// One item first reduces the base, then for each exponent bit up to the highest set
// one multiplies the accumulator in when the bit is set and squares the base value.
// Every modular product runs on the shared multiply-reduce unit: one multiply, then
// two-bit restoring reduction of the double-width product.
// Reset clears the sequencer and loads a modulus of 2; in_stall is low only when idle.
// A finished result sits in the output register; the next item transfers in while
// it waits, and a new result is held in the sequencer until the output slot frees.
module modular_exponentiation_core import modexp_pkg::*; #(
	parameter int unsigned OPERAND_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   modulus_wr_en,
	input  logic [FIELD_WIDTH-1:0] modulus_wr_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [FIELD_WIDTH-1:0] base_value,
	input  logic [FIELD_WIDTH-1:0] exponent,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [FIELD_WIDTH-1:0] power_result
);

	localparam int unsigned W = OPERAND_WIDTH;

	modexp_state_t      state_q, state_d;
	logic [W-1:0]       mod_q;
	logic [W-1:0]       exp_q;
	logic [W-1:0]       acc_q;
	logic [W-1:0]       sq_q;
	logic               out_valid_q;
	logic [W-1:0]       power_result_q;

	logic               in_xfer;
	logic               out_free;
	logic               mod_small;
	logic               mm_start;
	logic [W-1:0]       mm_a;
	logic [W-1:0]       mm_b;
	logic [W-1:0]       mm_result;
	modexp_mm_status_t  mm_st;

	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	// A modulus below 2 reduces everything to zero
	assign mod_small = mod_q < W'(2);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = mod_small ? ST_DONE : ST_BASE;
				end
			end
			ST_BASE:      state_d = ST_BASE_WAIT;
			ST_BASE_WAIT: begin
				if (mm_st.done) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				// Stop once no set exponent bit remains
				if (exp_q == '0) begin
					state_d = ST_DONE;
				end else if (exp_q[0]) begin
					state_d = ST_ACC_WAIT;
				end else begin
					state_d = ST_SQ_WAIT;
				end
			end
			ST_ACC_WAIT: begin
				if (mm_st.done) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ:        state_d = ST_SQ_WAIT;
			ST_SQ_WAIT: begin
				if (mm_st.done) begin
					state_d = ST_STEP;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: input stall, unit start and operand select
	always_comb begin
		in_stall = 1'b1;
		mm_start = 1'b0;
		mm_a     = sq_q;
		mm_b     = sq_q;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_BASE: begin
				// Reduce the base by multiplying with one
				mm_start = 1'b1;
				mm_b     = W'(1);
			end
			ST_STEP: begin
				if (exp_q != '0) begin
					mm_start = 1'b1;
					if (exp_q[0]) begin
						mm_a = acc_q;
					end
				end
			end
			ST_SQ: begin
				mm_start = 1'b1;
			end
			default: begin
				mm_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mod_q       <= W'(2);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (modulus_wr_en) begin
				mod_q <= modulus_wr_data[W-1:0];
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers: load on input transfer, advance on each finished unit product
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sq_q  <= base_value[W-1:0];
			exp_q <= exponent[W-1:0];
			acc_q <= mod_small ? '0 : W'(1);
		end
		if (mm_st.done) begin
			unique case (state_q)
				ST_BASE_WAIT: sq_q <= mm_result;
				ST_ACC_WAIT:  acc_q <= mm_result;
				ST_SQ_WAIT: begin
					sq_q  <= mm_result;
					exp_q <= exp_q >> 1;
				end
				default: begin
					sq_q <= sq_q;
				end
			endcase
		end
		if (state_q == ST_DONE && out_free) begin
			power_result_q <= acc_q;
		end
	end

	modexp_mulred #(
		.W (W)
	) u_mulred (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.m      (mod_q),
		.st     (mm_st),
		.result (mm_result)
	);

	assign out_valid    = out_valid_q;
	assign power_result = FIELD_WIDTH'(power_result_q);

	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		mm_start |-> !mm_st.busy)
		else $error("unit started while busy");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP && $past(state_q) == ST_BASE_WAIT) |->
		(sq_q < mod_q && acc_q < mod_q))
		else $error("operands not reduced at first step");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result presented without finished item");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
	import modexp_pkg::*;

	localparam int unsigned OPERAND_WIDTH = 32;
	localparam bit [63:0] OPERAND_MASK = (64'd1 << OPERAND_WIDTH) - 64'd1;
	// Allow the time of several worst-case items with no transfer at all
	localparam int unsigned STALL_LIMIT = 20000;
	// Quiet time after the last result, about one worst-case item
	localparam int unsigned TAIL_CYCLES = 2400;
	localparam int unsigned RANDOM_PHASES = 9;
	localparam int unsigned ITEMS_PER_PHASE = 30;

	typedef bit [FIELD_WIDTH-1:0] word_t;

	// Scoreboard: holds the modulus shadow and the queue of expected powers
	class modpow_scoreboard;
		word_t modulus;
		word_t expected_powers[$];
		int unsigned operands_taken;
		int unsigned powers_checked;
		int unsigned mismatches;

		function new();
			modulus = 2;
			operands_taken = 0;
			powers_checked = 0;
			mismatches = 0;
		endfunction

		// Right-to-left square-and-multiply with exact 64-bit products
		function word_t predict_power(word_t base_in, word_t exp_in);
			bit [63:0] m;
			bit [63:0] acc;
			bit [63:0] sq;
			bit [63:0] e;
			m = modulus & OPERAND_MASK;
			e = exp_in & OPERAND_MASK;
			if (m < 2)
				return '0;
			acc = 1;
			sq = (base_in & OPERAND_MASK) % m;
			for (int i = 0; i < OPERAND_WIDTH; i++) begin
				if (e[i])
					acc = (acc * sq) % m;
				sq = (sq * sq) % m;
			end
			return acc[FIELD_WIDTH-1:0];
		endfunction

		function void note_operands(word_t base_in, word_t exp_in);
			expected_powers.push_back(predict_power(base_in, exp_in));
			operands_taken++;
		endfunction

		task report_mismatch(string what);
			$display("[%0t] MISMATCH: %s", $time, what);
			mismatches++;
		endtask

		task check_power(word_t got);
			word_t want;
			powers_checked++;
			if (expected_powers.size() == 0) begin
				report_mismatch($sformatf("power_result %h with no transfer pending", got));
				return;
			end
			want = expected_powers.pop_front();
			if (got !== want)
				report_mismatch($sformatf("power_result got %h expected %h", got, want));
		endtask
	endclass

	logic  clk;
	logic  arst_n;
	logic  modulus_wr_en;
	word_t modulus_wr_data;
	logic  in_valid;
	logic  in_stall;
	word_t base_value;
	word_t exponent;
	logic  out_valid;
	logic  out_stall;
	word_t power_result;

	modpow_scoreboard sb = new();
	// Set to run both sides back to back with no idling
	bit steady;
	int unsigned modulus_writes;
	int unsigned idle_cycles;

	modular_exponentiation_core #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.modulus_wr_en  (modulus_wr_en),
		.modulus_wr_data(modulus_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.base_value     (base_value),
		.exponent       (exponent),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.power_result   (power_result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check every result transfer against the oldest expected power
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_power(power_result);
	end

	// Watchdog: count cycles with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[%0t] timeout: no transfer for %0d cycles", $time, idle_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Receiver: draw a stall length per result, drop stall, wait for the transfer
	initial begin : result_sink
		int unsigned hold;
		wait (arst_n === 1'b1);
		forever begin
			hold = steady ? 0 : $urandom_range(0, 11);
			repeat (hold) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Present one operand pair after a random gap (none in steady mode) and hold it until it transfers
	task send_item(input word_t b, input word_t e);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 11);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		base_value <= b;
		exponent <= e;
		do @(posedge clk); while (in_stall);
		sb.note_operands(b, e);
	endtask

	// Drop valid and hold off until every expected power has come back
	task drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_powers.size() != 0)
			@(posedge clk);
	endtask

	// Write the modulus once the block is idle, then advance the shadow copy
	task set_modulus(input word_t m);
		drain();
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		modulus_wr_en <= 1'b1;
		modulus_wr_data <= m;
		@(negedge clk);
		modulus_wr_en <= 1'b0;
		sb.modulus = m;
		modulus_writes++;
	endtask

	function word_t pick_modulus();
		word_t m;
		case ($urandom_range(0, 4))
			0: m = $urandom;
			1: m = $urandom_range(2, 1000);
			2: m = '1;
			3: m = $urandom | 32'h8000_0001;
			default: m = $urandom_range(2, 3);
		endcase
		if (m < 2)
			m = 2;
		return m;
	endfunction

	function word_t pick_base(input word_t m);
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom % m;
			2: return m;
			3: return m - 1;
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	// Exponents take a random bit length up to the full width; zero and all ones also appear
	function word_t pick_exponent();
		int unsigned bits;
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: begin
				bits = $urandom_range(1, FIELD_WIDTH);
				return word_t'($urandom) >> (FIELD_WIDTH - bits);
			end
		endcase
	endfunction

	initial begin : stimulus
		word_t m;
		clk_setup();
		arst_n = 1'b0;
		modulus_wr_en = 1'b0;
		modulus_wr_data = '0;
		in_valid = 1'b0;
		base_value = '0;
		exponent = '0;
		out_stall = 1'b0;
		steady = 1'b0;
		modulus_writes = 0;
		idle_cycles = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset modulus of 2: zero exponent gives 1, odd and even bases
		send_item(32'd0, 32'd0);
		send_item(32'hFFFF_FFFF, 32'd0);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(32'd2, 32'd5);

		// Largest modulus: extremes of both fields
		set_modulus(32'hFFFF_FFFF);
		send_item(32'd0, 32'd0);
		send_item(32'd0, 32'hFFFF_FFFF);
		send_item(32'hFFFF_FFFF, 32'd1);
		send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_item(32'hAAAA_AAAA, 32'h5555_5555);
		send_item(32'h5555_5555, 32'hAAAA_AAAA);

		// Modulus of one and of zero both answer zero
		set_modulus(32'd1);
		send_item(32'd7, 32'd0);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		set_modulus(32'd0);
		send_item(32'd5, 32'd3);
		send_item(32'hFFFF_FFFF, 32'd0);

		// Small key n = 61 * 53: encrypt 65 with e = 17, then decrypt with d = 2753
		set_modulus(32'd3233);
		send_item(32'd65, 32'd17);
		send_item(32'd2790, 32'd2753);
		send_item(32'd3233, 32'd9);
		send_item(32'd3234, 32'd9);

		// Power-of-two modulus with bases at, above and just below it
		set_modulus(32'h8000_0000);
		send_item(32'h8000_0000, 32'd3);
		send_item(32'hC000_0001, 32'hFFFF_FFFF);
		send_item(32'h7FFF_FFFF, 32'd2);

		set_modulus(32'd2);
		send_item(32'd3, 32'hFFFF_FFFF);

		// Random phases, each under a fresh modulus; every third runs back to back
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_modulus(pick_modulus());
			steady = (p % 3 == 1);
			m = sb.modulus;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if ($urandom_range(0, 19) == 0)
					drain();
				send_item(pick_base(m), pick_exponent());
			end
		end
		steady = 1'b0;

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.expected_powers.size() != 0)
			sb.report_mismatch($sformatf("%0d expected powers never arrived",
				sb.expected_powers.size()));
		$display("Covered %0d operand pairs over %0d modulus writes; %0d results compared.",
			sb.operands_taken, modulus_writes, sb.powers_checked);
		$display("Included zero and full-width fields, moduli of 0, 1, 2 and 2^32-1.");
		if (sb.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Start the stimulus on a defined clock level
	task clk_setup();
		#0;
	endtask

endmodule

>>> modular_exponentiation_core.f
rtl/core/modexp_pkg.sv
rtl/core/modexp_mulred.sv
rtl/core/modular_exponentiation_core.sv
test/tb.sv
